>>> hw/rtl/rvmd_pkg.sv
// Package with the operation codes and word types of the RV32M multiply/divide unit.
package rvmd_pkg;

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [4:0]  dest_reg;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic [4:0]  dest_reg_out;
    } t_out;

    localparam int XLEN = 32;

endpackage

>>> hw/rtl/rv32m_multiply_divide.sv
// Top level of the pipelined RV32M multiply/divide unit.
// The unit accepts one word every cycle and never raises busy. Each result appears on o_out
// with o_valid high for one cycle. The product is formed from four registered 17x17 partial
// products and then registered, and the divider is a chain of 32 registered steps that each
// settle one quotient bit; a final register holds the sign-fixed, selected result.
// Multiplications travel through the same chain so results leave in order.
module rv32m_multiply_divide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rvmd_pkg::t_in i_in,
    output logic          o_valid,
    output rvmd_pkg::t_out o_out
);
    import rvmd_pkg::*;

    localparam int NSTEP = XLEN;

    t_op         in_op;
    logic        sa, sb, a_neg, b_neg, is_sdiv;
    logic [32:0] a33, b33;
    logic [31:0] a_mag, b_mag;

    logic               r_v1;
    t_op                r_op1;
    logic [4:0]         r_rd1;
    logic signed [33:0] r_pll, r_plh, r_phl, r_phh;
    logic [31:0]        r_dvd1, r_dvs1;
    logic               r_nq1, r_nr1;

    logic signed [65:0] prod;
    logic [31:0]        mul_sel;

    logic        r_v   [0:NSTEP];
    t_op         r_op  [0:NSTEP];
    logic [4:0]  r_rd  [0:NSTEP];
    logic [31:0] r_mul [0:NSTEP];
    logic [31:0] r_rem [0:NSTEP];
    logic [31:0] r_quo [0:NSTEP];
    logic [31:0] r_dvs [0:NSTEP];
    logic        r_nq  [0:NSTEP];
    logic        r_nr  [0:NSTEP];

    logic [31:0] q_fix, r_fix;
    logic [31:0] n_result;
    logic        r_valid;
    t_out        r_out;

    assign busy = 1'b0;

    always_comb begin
        in_op   = t_op'(i_in.operation);
        sa      = (in_op == OP_MULH) || (in_op == OP_MULHSU);
        sb      = (in_op == OP_MULH);
        a33     = {sa & i_in.operand_a[31], i_in.operand_a};
        b33     = {sb & i_in.operand_b[31], i_in.operand_b};
        is_sdiv = (in_op == OP_DIV) || (in_op == OP_REM);
        a_neg   = is_sdiv & i_in.operand_a[31];
        b_neg   = is_sdiv & i_in.operand_b[31];
        a_mag   = a_neg ? (32'd0 - i_in.operand_a) : i_in.operand_a;
        b_mag   = b_neg ? (32'd0 - i_in.operand_b) : i_in.operand_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_op1  <= in_op;
        r_rd1  <= i_in.dest_reg;
        r_pll  <= $signed({1'b0, a33[15:0]}) * $signed({1'b0, b33[15:0]});
        r_plh  <= $signed({1'b0, a33[15:0]}) * $signed(b33[32:16]);
        r_phl  <= $signed(a33[32:16]) * $signed({1'b0, b33[15:0]});
        r_phh  <= $signed(a33[32:16]) * $signed(b33[32:16]);
        r_dvd1 <= a_mag;
        r_dvs1 <= b_mag;
        r_nq1  <= (a_neg ^ b_neg) && (i_in.operand_b != 32'd0);
        r_nr1  <= a_neg;
    end

    always_comb begin
        prod = (66'(r_phh) <<< 32) + (66'(r_phl) <<< 16) + (66'(r_plh) <<< 16) + 66'(r_pll);
        mul_sel = (r_op1 == OP_MUL) ? prod[31:0] : prod[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_v1;
        end
        r_op[0]  <= r_op1;
        r_rd[0]  <= r_rd1;
        r_mul[0] <= mul_sel;
        r_rem[0] <= 32'd0;
        r_quo[0] <= r_dvd1;
        r_dvs[0] <= r_dvs1;
        r_nq[0]  <= r_nq1;
        r_nr[0]  <= r_nr1;
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [32:0] sh;
        logic [33:0] diff;
        logic        ge;

        always_comb begin
            sh   = {r_rem[k], r_quo[k][31]};
            diff = {1'b0, sh} - {2'b00, r_dvs[k]};
            ge   = ~diff[33];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_op[k+1]  <= r_op[k];
            r_rd[k+1]  <= r_rd[k];
            r_mul[k+1] <= r_mul[k];
            r_rem[k+1] <= ge ? diff[31:0] : sh[31:0];
            r_quo[k+1] <= {r_quo[k][30:0], ge};
            r_dvs[k+1] <= r_dvs[k];
            r_nq[k+1]  <= r_nq[k];
            r_nr[k+1]  <= r_nr[k];
        end
    end

    always_comb begin
        q_fix = r_nq[NSTEP] ? (32'd0 - r_quo[NSTEP]) : r_quo[NSTEP];
        r_fix = r_nr[NSTEP] ? (32'd0 - r_rem[NSTEP]) : r_rem[NSTEP];
        case (r_op[NSTEP])
            OP_DIV, OP_DIVU: n_result = q_fix;
            OP_REM, OP_REMU: n_result = r_fix;
            default:         n_result = r_mul[NSTEP];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_v[NSTEP];
        end
        r_out.result       <= n_result;
        r_out.dest_reg_out <= r_rd[NSTEP];
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule
